// ----- hw/rtl/multi_channel_led_blink_controller_macros.svh -----
// ============================================================================
// Assertion macros for the LED blink controller
// Shared property shorthands, clocked on clk and disabled during reset.
// ============================================================================
`ifndef MULTI_CHANNEL_LED_BLINK_CONTROLLER_MACROS_SVH
`define MULTI_CHANNEL_LED_BLINK_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCLBC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MCLBC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/mclbc_pkg.sv -----
// ============================================================================
// LED blink controller package
// Item types, mode and register codes, and defaults shared by all modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mclbc_pkg;

	localparam int LED_COUNT_DEFAULT   = 16;
	localparam int COUNT_WIDTH_DEFAULT = 16;
	localparam int QUEUE_DEPTH         = 2;
	localparam int PIN_COUNT           = 16;

	localparam logic [15:0] BLINK_PERIOD_RESET   = 16'd500;
	localparam logic [15:0] FAST_PERIOD_RESET    = 16'd100;
	localparam logic [15:0] SINGLE_LENGTH_RESET  = 16'd50;
	localparam logic [15:0] RECEIVE_TIMEOUT_RESET = 16'd1000;
	localparam logic [15:0] PRESENT_RESET        = 16'hFFFF;

	typedef enum logic [2:0] {
		MODE_OFF     = 3'd0,
		MODE_ON      = 3'd1,
		MODE_BLINK   = 3'd2,
		MODE_FAST    = 3'd3,
		MODE_ONCE    = 3'd4,
		MODE_ONCE_ON = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		REG_BLINK_PERIOD    = 3'd0,
		REG_FAST_PERIOD     = 3'd1,
		REG_SINGLE_LENGTH   = 3'd2,
		REG_RECEIVE_TIMEOUT = 3'd3,
		REG_PRESENT         = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_TICK = 2'd1,
		OP_BAD  = 2'd2
	} op_t;

	typedef enum logic {
		KIND_SET  = 1'b0,
		KIND_TICK = 1'b1
	} kind_t;

	typedef struct packed {
		logic       kind;
		logic [3:0] led_index;
		logic [2:0] new_mode;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pin_levels;
		logic [15:0] timeout_left;
		logic        bad_mode;
	} out_item_t;

	typedef struct packed {
		op_t        op;
		logic       in_range;
		logic [3:0] led_index;
		mode_t      mode;
	} cmd_t;

	typedef struct packed {
		logic [15:0] blink_period;
		logic [15:0] fast_blink_period;
		logic [15:0] single_blink_length;
		logic [15:0] receive_timeout;
		logic [15:0] channel_present;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mclbc_front.sv -----
// ============================================================================
// LED blink controller front end
// Accepts input items and decodes them into commands for the queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mclbc_front import mclbc_pkg::*; #(
	parameter int LED_COUNT = LED_COUNT_DEFAULT
) (
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_item_t in_item,
	input  wire logic     q_full,
	output logic          q_push,
	output cmd_t          q_cmd
);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.led_index = in_item.led_index;
		q_cmd.in_range  = (32'(in_item.led_index) < LED_COUNT);
		q_cmd.mode      = MODE_OFF;
		unique case (in_item.kind)
			KIND_TICK: begin
				q_cmd.op = OP_TICK;
			end
			default: begin
				if (in_item.new_mode > MODE_ONCE_ON) begin
					q_cmd.op = OP_BAD;
				end else begin
					q_cmd.op   = OP_SET;
					q_cmd.mode = mode_t'(in_item.new_mode);
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/mclbc_queue.sv -----
// ============================================================================
// LED blink controller command queue
// Short FIFO that decouples the front end from the LED state walker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mclbc_queue import mclbc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	output logic      full,
	input  wire logic pop,
	output logic      avail,
	output cmd_t      head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign avail = (count_q != '0);
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/mclbc_back.sv -----
// ============================================================================
// LED blink controller back end
// Applies set-mode commands and walks the LED state one entry per cycle on ticks.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none
`include "multi_channel_led_blink_controller_macros.svh"

module mclbc_back import mclbc_pkg::*; #(
	parameter int LED_COUNT   = LED_COUNT_DEFAULT,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      q_avail,
	input  wire cmd_t      q_head,
	output logic           q_pop,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_item_t      out_item
);

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
	localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [15:0] v);
		logic [32:0] w;
		w = 33'(v);
		sat_cnt = (w > CNT_MAX) ? '1 : w[COUNT_WIDTH-1:0];
	endfunction

	function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] a);
		logic [32:0] w;
		w = 33'(a);
		sat16 = (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	state_t                 state_q;
	logic [IDX_W-1:0]       walk_q;
	logic [IDX_W-1:0]       tgt_q;
	logic                   tgt_ok_q;
	logic [15:0]            tl_q;
	mode_t                  mode_q     [LED_COUNT];
	logic                   lamp_q     [LED_COUNT];
	logic [COUNT_WIDTH-1:0] period_q   [LED_COUNT];
	logic [COUNT_WIDTH-1:0] activity_q [LED_COUNT];
	logic [PIN_COUNT-1:0]   pins_q;
	logic                   out_valid_q;
	out_item_t              out_item_q;

	logic                   out_free;
	logic                   res_load;
	logic [EXT_W-1:0]       head_ext;
	logic [IDX_W-1:0]       head_addr;
	logic [EXT_W-1:0]       walk_ext;
	logic [IDX_W-1:0]       addr;
	mode_t                  r_mode;
	logic                   r_lamp;
	logic [COUNT_WIDTH-1:0] r_per;
	logic [COUNT_WIDTH-1:0] r_act;

	logic                   s_lamp;
	logic [COUNT_WIDTH-1:0] s_per;
	logic [COUNT_WIDTH-1:0] s_act;

	logic                   t_pin;
	mode_t                  t_mode;
	logic                   t_lamp;
	logic [COUNT_WIDTH-1:0] t_reload;
	logic [COUNT_WIDTH-1:0] t_per;
	logic [COUNT_WIDTH-1:0] t_act;

	logic                   pin_wr;
	logic [3:0]             pin_sel;
	logic                   pin_val;
	logic [PIN_COUNT-1:0]   pins_d;
	logic                   walk_hit;
	logic [15:0]            tl_d;

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == ST_IDLE) && q_avail && out_free;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign res_load  = ((state_q == ST_IDLE) && q_pop && (q_head.op != OP_TICK))
	                || ((state_q == ST_WALK) && (walk_q == LAST_IDX));

	assign head_ext  = EXT_W'(q_head.led_index);
	assign head_addr = head_ext[IDX_W-1:0];
	assign walk_ext  = EXT_W'(walk_q);
	assign addr      = (state_q == ST_WALK) ? walk_q : head_addr;

	assign r_mode = mode_q[addr];
	assign r_lamp = lamp_q[addr];
	assign r_per  = period_q[addr];
	assign r_act  = activity_q[addr];

	always_comb begin
		s_lamp = 1'b1;
		s_per  = '0;
		s_act  = r_act;
		case (q_head.mode) inside
			MODE_OFF: begin
				s_lamp = 1'b0;
			end
			MODE_BLINK: begin
				s_per = sat_cnt(cfg.blink_period);
			end
			MODE_FAST: begin
				s_per = sat_cnt(cfg.fast_blink_period);
			end
			MODE_ONCE: begin
				s_per = sat_cnt(cfg.single_blink_length);
			end
			MODE_ONCE_ON: begin
				s_lamp = 1'b0;
				s_per  = sat_cnt(cfg.single_blink_length);
				s_act  = sat_cnt(cfg.receive_timeout);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		t_mode   = r_mode;
		t_lamp   = r_lamp;
		t_pin    = r_lamp;
		t_reload = r_per;
		t_reload = (r_mode == MODE_FAST) ? sat_cnt(cfg.fast_blink_period)
		                                 : sat_cnt(cfg.blink_period);
		t_per    = r_per;
		case (r_mode) inside
			MODE_OFF, MODE_ON: begin
				t_pin = (r_mode == MODE_ON);
				t_per = '0;
			end
			MODE_BLINK, MODE_FAST: begin
				if (r_per == '0) begin
					t_per  = t_reload;
					t_lamp = !r_lamp;
				end
			end
			MODE_ONCE, MODE_ONCE_ON: begin
				if (r_per == '0) begin
					t_mode = (r_mode == MODE_ONCE) ? MODE_OFF : MODE_ON;
					t_lamp = (r_mode == MODE_ONCE_ON);
				end
			end
			default: begin
			end
		endcase
		if (t_per != '0) begin
			t_per = t_per - 1'b1;
		end
		t_act = (r_act != '0) ? r_act - 1'b1 : r_act;
	end

	always_comb begin
		pins_d = pins_q;
		if (state_q == ST_WALK) begin
			pin_wr  = (32'(walk_q) < PIN_COUNT);
			pin_sel = walk_ext[3:0];
			pin_val = t_pin;
		end else begin
			pin_wr  = q_pop && (q_head.op == OP_SET) && q_head.in_range;
			pin_sel = q_head.led_index;
			pin_val = s_lamp;
		end
		if (pin_wr) begin
			pins_d[pin_sel] = pin_val && cfg.channel_present[pin_sel];
		end
		walk_hit = tgt_ok_q && (walk_q == tgt_q);
		tl_d     = walk_hit ? sat16(t_act) : tl_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			walk_q      <= '0;
			tgt_ok_q    <= 1'b0;
			pins_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LED_COUNT; i++) begin
				mode_q[i]     <= MODE_OFF;
				lamp_q[i]     <= 1'b0;
				period_q[i]   <= '0;
				activity_q[i] <= '0;
			end
		end else begin
			pins_q <= pins_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_head.op == OP_TICK) begin
							state_q  <= ST_WALK;
							walk_q   <= '0;
							tgt_ok_q <= q_head.in_range;
						end else begin
							if (q_head.op == OP_SET && q_head.in_range) begin
								mode_q[head_addr]     <= q_head.mode;
								lamp_q[head_addr]     <= s_lamp;
								period_q[head_addr]   <= s_per;
								activity_q[head_addr] <= s_act;
							end
						end
					end
				end
				ST_WALK: begin
					mode_q[walk_q]     <= t_mode;
					lamp_q[walk_q]     <= t_lamp;
					period_q[walk_q]   <= t_per;
					activity_q[walk_q] <= t_act;
					if (walk_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end else begin
						walk_q <= walk_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop) begin
			tgt_q <= head_addr;
			tl_q  <= '0;
			out_item_q.pin_levels   <= pins_d & cfg.channel_present;
			out_item_q.bad_mode     <= (q_head.op == OP_BAD);
			if (q_head.op == OP_SET) begin
				out_item_q.timeout_left <= q_head.in_range ? sat16(s_act) : '0;
			end else begin
				out_item_q.timeout_left <= q_head.in_range ? sat16(r_act) : '0;
			end
		end else if (state_q == ST_WALK) begin
			tl_q <= tl_d;
			if (walk_q == LAST_IDX) begin
				out_item_q.pin_levels   <= pins_d & cfg.channel_present;
				out_item_q.timeout_left <= tl_d;
				out_item_q.bad_mode     <= 1'b0;
			end
		end
	end

	`MCLBC_ASSERT_SAME(a_state_onehot, 1'b1, $onehot(state_q), "walker state is not one-hot")
	`MCLBC_ASSERT_SAME(a_walk_range, state_q == ST_WALK, 32'(walk_q) < LED_COUNT,
		"walk index beyond the last LED")
	`MCLBC_ASSERT_SAME(a_walk_no_result, state_q == ST_WALK, !out_valid_q,
		"result pending while a tick is being walked")
	`MCLBC_ASSERT_NEXT(a_walk_done, state_q == ST_WALK && walk_q == LAST_IDX,
		out_valid_q && state_q == ST_IDLE, "tick walk ended without a result")

endmodule

`default_nettype wire

// ----- hw/rtl/multi_channel_led_blink_controller.sv -----
// ============================================================================
// Multi-channel LED blink controller
// Per-LED blink modes driven by set-mode and tick items, with activity timeouts.
// ============================================================================
//
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_item  (kind, led_index, new_mode)
// out       output     out_valid / out_stall out_item (pin_levels, timeout_left, bad_mode)
// cfg       input      cfg_write            cfg_index, cfg_data
//
// A set-mode item or a rejected item is handled by the back end when it
// leaves the queue. For a tick item the back end walks the LED state
// through one read and write port, one LED per cycle.
// Reset clears all LED state at once, so items are accepted from the first
// cycle after reset. The front end accepts items while the queue has room,
// even when a result is held by a stalled output.
//
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_led_blink_controller import mclbc_pkg::*; #(
	parameter int LED_COUNT   = LED_COUNT_DEFAULT,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_item_t    in_item,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_item_t        out_item,
	input  wire logic        cfg_write,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	cfg_t cfg_q;
	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic q_avail;
	cmd_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blink_period        <= BLINK_PERIOD_RESET;
			cfg_q.fast_blink_period   <= FAST_PERIOD_RESET;
			cfg_q.single_blink_length <= SINGLE_LENGTH_RESET;
			cfg_q.receive_timeout     <= RECEIVE_TIMEOUT_RESET;
			cfg_q.channel_present     <= PRESENT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BLINK_PERIOD:    cfg_q.blink_period        <= cfg_data;
				REG_FAST_PERIOD:     cfg_q.fast_blink_period   <= cfg_data;
				REG_SINGLE_LENGTH:   cfg_q.single_blink_length <= cfg_data;
				REG_RECEIVE_TIMEOUT: cfg_q.receive_timeout     <= cfg_data;
				REG_PRESENT:         cfg_q.channel_present     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mclbc_front #(
		.LED_COUNT(LED_COUNT)
	) u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (q_cmd)
	);

	mclbc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_cmd),
		.full    (q_full),
		.pop     (q_pop),
		.avail   (q_avail),
		.head    (q_head)
	);

	mclbc_back #(
		.LED_COUNT  (LED_COUNT),
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_avail  (q_avail),
		.q_head   (q_head),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

endmodule

`default_nettype wire
